>>> design/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pps_pkg.sv
// Shared types for the preemptive priority scheduler: item payloads,
// controller commands and datapath status. No dependencies.
package pps_pkg;

  // Item kind codes
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_ARRIVAL = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  arrival_id;
    logic [7:0]  arrival_priority;
    logic [15:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic        running_valid;
    logic [7:0]  running_id;
    logic [7:0]  running_priority;
    logic [15:0] running_time_left;
    logic [4:0]  queue_count;
    logic        overflow;
  } out_item_t;

  // Ready queue operation
  typedef enum logic [1:0] {
    QOP_NONE,
    QOP_ENQ,
    QOP_DEQ
  } qop_t;

  // Source of a queue insertion
  typedef enum logic [1:0] {
    ENQ_ARR,
    ENQ_RUN,
    ENQ_HOLD
  } enq_src_t;

  // Source of the running task registers
  typedef enum logic [1:0] {
    RUN_KEEP,
    RUN_ARR,
    RUN_HEAD
  } run_src_t;

  typedef struct packed {
    logic     arr_load;   // capture input item
    qop_t     q_op;
    enq_src_t enq_src;
    run_src_t run_src;
    logic     hold_load;  // park running task during a swap
    logic     run_set;
    logic     run_clr;
    logic     run_dec;    // decrement time of the selected running task
    logic     ovf_clr;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic run_valid;
    logic run_time_zero;
    logic q_empty;
    logic q_full;
    logic head_gt_run;
    logic arr_gt_run;
  } dp_stat_t;

endpackage

>>> design/pps_queue.sv
// Ready queue: a row of cells kept sorted by descending priority.
// Insert finds its slot by a compare in every cell; remove shifts down. Uses pps_pkg.
module pps_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PRIO_BITS   = 8,
  parameter int TIME_BITS   = 16,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pps_pkg::qop_t        op,
  input  logic [7:0]           enq_id,
  input  logic [PRIO_BITS-1:0] enq_prio,
  input  logic [TIME_BITS-1:0] enq_time,
  output logic [7:0]           head_id,
  output logic [PRIO_BITS-1:0] head_prio,
  output logic [TIME_BITS-1:0] head_time,
  output logic [CNT_W-1:0]     count,
  output logic                 full,
  output logic                 empty
);
  import pps_pkg::*;

  logic [7:0]           q_id_r   [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] q_prio_r [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] q_time_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [QUEUE_DEPTH-1:0] keep;   // cell holds an entry that stays ahead of the new one
  logic do_enq, do_deq;

  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);
  assign do_enq = (op == QOP_ENQ) && !full;
  assign do_deq = (op == QOP_DEQ) && !empty;

  // Cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 prev_keep;
    logic [7:0]           prev_id, next_id;
    logic [PRIO_BITS-1:0] prev_prio, next_prio;
    logic [TIME_BITS-1:0] prev_time, next_time;

    assign keep[i] = (CNT_W'(i) < count_r) && (q_prio_r[i] >= enq_prio);

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign prev_id   = enq_id;
      assign prev_prio = enq_prio;
      assign prev_time = enq_time;
    end else begin : g_mid
      assign prev_keep = keep[i-1];
      assign prev_id   = q_id_r[i-1];
      assign prev_prio = q_prio_r[i-1];
      assign prev_time = q_time_r[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_id   = q_id_r[i];
      assign next_prio = q_prio_r[i];
      assign next_time = q_time_r[i];
    end else begin : g_inner
      assign next_id   = q_id_r[i+1];
      assign next_prio = q_prio_r[i+1];
      assign next_time = q_time_r[i+1];
    end

    // insertion: slot of the new entry takes it, cells behind shift up
    always_ff @(posedge clk) begin
      if (do_enq && !keep[i]) begin
        q_id_r[i]   <= prev_keep ? enq_id   : prev_id;
        q_prio_r[i] <= prev_keep ? enq_prio : prev_prio;
        q_time_r[i] <= prev_keep ? enq_time : prev_time;
      end else if (do_deq) begin
        q_id_r[i]   <= next_id;
        q_prio_r[i] <= next_prio;
        q_time_r[i] <= next_time;
      end
    end
  end

  // Fill count
  always_comb begin
    count_nxt = count_r;
    if (do_enq) begin
      count_nxt = count_r + 1'b1;
    end else if (do_deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count     = count_r;
  assign head_id   = q_id_r[0];
  assign head_prio = q_prio_r[0];
  assign head_time = q_time_r[0];

endmodule

>>> design/pps_datapath.sv
// Scheduler datapath: captured item, running task, swap holding register,
// ready queue and result register. Uses pps_pkg and pps_queue.
module pps_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PRIO_BITS   = 8,
  parameter int TIME_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pps_pkg::in_item_t  in_item,
  input  pps_pkg::ctl_cmd_t  cmd,
  output pps_pkg::dp_stat_t  stat,
  output pps_pkg::out_item_t out_item
);
  import pps_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Field width adaptation
  logic [PRIO_BITS+7:0]  arr_prio_ext;
  logic [TIME_BITS+15:0] arr_time_ext;
  logic [PRIO_BITS+7:0]  out_prio_ext;
  logic [TIME_BITS+15:0] out_time_ext;
  logic [CNT_W+4:0]      out_cnt_ext;

  logic [7:0]           arr_id_r;
  logic [PRIO_BITS-1:0] arr_prio_r;
  logic [TIME_BITS-1:0] arr_time_r;

  logic                 run_valid_r;
  logic [7:0]           run_id_r;
  logic [PRIO_BITS-1:0] run_prio_r;
  logic [TIME_BITS-1:0] run_time_r;

  logic [7:0]           hold_id_r;
  logic [PRIO_BITS-1:0] hold_prio_r;
  logic [TIME_BITS-1:0] hold_time_r;

  logic                 ovf_r;
  out_item_t            out_r;

  logic [7:0]           enq_id;
  logic [PRIO_BITS-1:0] enq_prio;
  logic [TIME_BITS-1:0] enq_time;

  logic [7:0]           src_id;
  logic [PRIO_BITS-1:0] src_prio;
  logic [TIME_BITS-1:0] src_time;
  logic [TIME_BITS-1:0] run_time_nxt;

  logic [7:0]           head_id;
  logic [PRIO_BITS-1:0] head_prio;
  logic [TIME_BITS-1:0] head_time;
  logic [CNT_W-1:0]     q_count;
  logic                 q_full, q_empty;

  assign arr_prio_ext = {{PRIO_BITS{1'b0}}, in_item.arrival_priority};
  assign arr_time_ext = {{TIME_BITS{1'b0}}, in_item.arrival_time};

  // Captured arrival
  always_ff @(posedge clk) begin
    if (cmd.arr_load) begin
      arr_id_r   <= in_item.arrival_id;
      arr_prio_r <= arr_prio_ext[PRIO_BITS-1:0];
      arr_time_r <= arr_time_ext[TIME_BITS-1:0];
    end
  end

  // Insertion source
  always_comb begin
    case (cmd.enq_src)
      ENQ_RUN: begin
        enq_id = run_id_r;  enq_prio = run_prio_r;  enq_time = run_time_r;
      end
      ENQ_HOLD: begin
        enq_id = hold_id_r; enq_prio = hold_prio_r; enq_time = hold_time_r;
      end
      default: begin
        enq_id = arr_id_r;  enq_prio = arr_prio_r;  enq_time = arr_time_r;
      end
    endcase
  end

  pps_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRIO_BITS   (PRIO_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (cmd.q_op),
    .enq_id    (enq_id),
    .enq_prio  (enq_prio),
    .enq_time  (enq_time),
    .head_id   (head_id),
    .head_prio (head_prio),
    .head_time (head_time),
    .count     (q_count),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Running task source and tick decrement
  always_comb begin
    case (cmd.run_src)
      RUN_ARR: begin
        src_id = arr_id_r;  src_prio = arr_prio_r;  src_time = arr_time_r;
      end
      RUN_HEAD: begin
        src_id = head_id;   src_prio = head_prio;   src_time = head_time;
      end
      default: begin
        src_id = run_id_r;  src_prio = run_prio_r;  src_time = run_time_r;
      end
    endcase
    run_time_nxt = (cmd.run_dec && (src_time != '0)) ? src_time - 1'b1 : src_time;
  end

  always_ff @(posedge clk) begin
    run_id_r   <= src_id;
    run_prio_r <= src_prio;
    run_time_r <= run_time_nxt;
    if (cmd.hold_load) begin
      hold_id_r   <= run_id_r;
      hold_prio_r <= run_prio_r;
      hold_time_r <= run_time_r;
    end
  end

  // Running flag and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      if (cmd.run_set) begin
        run_valid_r <= 1'b1;
      end else if (cmd.run_clr) begin
        run_valid_r <= 1'b0;
      end
      if (cmd.ovf_clr) begin
        ovf_r <= 1'b0;
      end else if ((cmd.q_op == QOP_ENQ) && q_full) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Result register
  assign out_prio_ext = {8'b0, run_prio_r};
  assign out_time_ext = {16'b0, run_time_r};
  assign out_cnt_ext  = {5'b0, q_count};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.running_valid     <= run_valid_r;
      out_r.running_id        <= run_valid_r ? run_id_r : 8'd0;
      out_r.running_priority  <= run_valid_r ? out_prio_ext[7:0] : 8'd0;
      out_r.running_time_left <= run_valid_r ? out_time_ext[15:0] : 16'd0;
      out_r.queue_count       <= out_cnt_ext[4:0];
      out_r.overflow          <= ovf_r;
    end
  end

  assign out_item = out_r;

  // Status to the controller
  assign stat.run_valid     = run_valid_r;
  assign stat.run_time_zero = (run_time_r == '0);
  assign stat.q_empty       = q_empty;
  assign stat.q_full        = q_full;
  assign stat.head_gt_run   = (head_prio > run_prio_r);
  assign stat.arr_gt_run    = (arr_prio_r > run_prio_r);

endmodule

>>> design/pps_ctrl.sv
// Scheduler controller: sequences arrival and tick steps as datapath commands
// and owns both handshakes. Uses pps_pkg.
module pps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pps_pkg::dp_stat_t stat,
  output pps_pkg::ctl_cmd_t cmd
);
  import pps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARR,
    S_SWAP,
    S_PUT,
    S_TAKE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.q_op    = QOP_NONE;
    cmd.enq_src = ENQ_ARR;
    cmd.run_src = RUN_KEEP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.arr_load = 1'b1;
          cmd.ovf_clr  = 1'b1;
          state_nxt    = (in_kind == KIND_ARRIVAL) ? S_ARR : S_SWAP;
        end
      end
      S_ARR: begin
        if (!stat.run_valid) begin
          cmd.run_src = RUN_ARR;
          cmd.run_set = 1'b1;
        end else if (stat.arr_gt_run && !stat.run_time_zero) begin
          // preempt: running task goes back into the queue
          cmd.q_op    = QOP_ENQ;
          cmd.enq_src = ENQ_RUN;
          cmd.run_src = RUN_ARR;
        end else begin
          cmd.q_op    = QOP_ENQ;
          cmd.enq_src = ENQ_ARR;
        end
        state_nxt = S_DONE;
      end
      S_SWAP: begin
        if (stat.run_valid && !stat.run_time_zero && !stat.q_empty && stat.head_gt_run) begin
          cmd.q_op      = QOP_DEQ;
          cmd.run_src   = RUN_HEAD;
          cmd.hold_load = 1'b1;
          state_nxt     = S_PUT;
        end else begin
          state_nxt = S_TAKE;
        end
      end
      S_PUT: begin
        cmd.q_op    = QOP_ENQ;
        cmd.enq_src = ENQ_HOLD;
        state_nxt   = S_TAKE;
      end
      S_TAKE: begin
        if (!stat.run_valid || stat.run_time_zero) begin
          if (!stat.q_empty) begin
            cmd.q_op    = QOP_DEQ;
            cmd.run_src = RUN_HEAD;
            cmd.run_set = 1'b1;
          end else begin
            cmd.run_clr = 1'b1;
          end
        end
        cmd.run_dec = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register holds until taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> design/preemptive_priority_scheduler_core.sv
// Preemptive priority scheduler, top level: controller plus datapath.
// Uses pps_pkg, pps_ctrl, pps_datapath and assert_macros.svh.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | pps_pkg::in_item_t  (tick or arrival)
//   out     | output    | out_valid/out_stall| pps_pkg::out_item_t (running task)
//
// One item at a time. An arrival passes S_ARR; a tick S_SWAP, then S_PUT when
// the queue head displaces the running task, then S_TAKE (one queue insert or
// remove per cycle). S_DONE loads the result; the next item is taken next cycle.
// Reset (rst_n low, synchronous) empties the queue and stops the running task.
// A result waits in the output register; the next item is accepted
// meanwhile, and its own result waits until the register is taken.
`include "assert_macros.svh"

module preemptive_priority_scheduler_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int PRIO_BITS   = 8,
  parameter int TIME_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pps_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pps_pkg::out_item_t out_item
);
  import pps_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_item.kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pps_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRIO_BITS   (PRIO_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  // Checks
  `PPS_ASSERT_IMP(a_deq_nonempty, cmd.q_op == QOP_DEQ, !stat.q_empty, "remove from empty queue")
  `PPS_ASSERT_NXT(a_swap_put_back, cmd.hold_load, (cmd.q_op == QOP_ENQ) && !stat.q_full, "swap put-back lost")
  `PPS_ASSERT_IMP(a_out_free, cmd.out_load, !out_valid || !out_stall, "result overwritten")

endmodule
